// ===== src/tgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt gesture detector package
// Shared constants, register indexes, gesture codes and pipeline control types.
// ----------------------------------------------------------------------------
package tgd_pkg;

  localparam int unsigned GROUP_SAMPLES_DEF = 6;
  localparam int unsigned CAL_SAMPLES_DEF   = 15;
  localparam int unsigned WINDOW_DEPTH_DEF  = 3;

  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [1:0] REG_TILT_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RELEASE_LEVEL  = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_MS    = 2'd2;

  localparam logic [14:0] TILT_THRESHOLD_RST = 15'd5792;
  localparam logic [14:0] RELEASE_LEVEL_RST  = 15'd2048;
  localparam logic [15:0] DEBOUNCE_MS_RST    = 16'd200;

  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_FRONT = 3'd1,
    GEST_BACK  = 3'd2,
    GEST_LEFT  = 3'd3,
    GEST_RIGHT = 3'd4
  } gesture_e;

  // What a transfer leaving the accumulator carries: a calibration sum or a group sum.
  typedef enum logic {
    KIND_CAL = 1'b0,
    KIND_GRP = 1'b1
  } kind_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } acc_ctl_t;

endpackage
`default_nettype wire

// ===== src/tgd_cdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Constant divider
// Signed division by a fixed divisor, truncated toward zero and saturated to
// 16 bits, done as a reciprocal multiplication over two register stages.
// ----------------------------------------------------------------------------
module tgd_cdiv #(
  parameter int unsigned IN_W    = 20,
  parameter int unsigned DIVISOR = 3
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic signed [IN_W-1:0] val_i,
  output logic signed [15:0]          q_o
);

  localparam int unsigned SH = IN_W + $clog2(DIVISOR);
  localparam int unsigned RW = SH + 1;
  localparam int unsigned PW = IN_W + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic              neg_d;
  logic [IN_W-1:0]   mag_d;
  logic [PW-1:0]     prod_d;
  logic [PW-1:0]     prod_q;
  logic              neg_q;
  logic [IN_W:0]     quo;
  logic signed [15:0] q_d;
  logic signed [15:0] q_q;

  always_comb begin
    neg_d  = val_i[IN_W-1];
    mag_d  = neg_d ? IN_W'(-val_i) : IN_W'(val_i);
    prod_d = PW'(mag_d) * PW'(RECIP);
  end

  always_comb begin
    quo = prod_q[SH +: IN_W+1];
    if (!neg_q && quo > (IN_W+1)'(32767)) begin
      q_d = 16'sh7FFF;
    end else if (neg_q && quo > (IN_W+1)'(32768)) begin
      q_d = -16'sh8000;
    end else if (neg_q) begin
      q_d = 16'(-quo[15:0]);
    end else begin
      q_d = quo[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      neg_q  <= neg_d;
      q_q    <= q_d;
    end
  end

  assign q_o = q_q;

endmodule
`default_nettype wire

// ===== src/tgd_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample accumulator
// Counts the calibration run and then the sample groups, summing the raw
// samples and passing each finished sum on with its kind.
// ----------------------------------------------------------------------------
module tgd_accum import tgd_pkg::*; #(
  parameter int unsigned CAL_SAMPLES   = CAL_SAMPLES_DEF,
  parameter int unsigned GROUP_SAMPLES = GROUP_SAMPLES_DEF,
  parameter int unsigned RAW_W         = 20,
  parameter int unsigned ZW            = 19
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [15:0]      x_i,
  input  wire logic signed [15:0]      y_i,
  input  wire logic signed [15:0]      z_i,
  output acc_ctl_t                     ctl_o,
  output logic signed [RAW_W-1:0]      sum_x_o,
  output logic signed [RAW_W-1:0]      sum_y_o,
  output logic signed [ZW-1:0]         sum_z_o
);

  localparam int unsigned NMAX  = (CAL_SAMPLES > GROUP_SAMPLES) ? CAL_SAMPLES : GROUP_SAMPLES;
  localparam int unsigned CNT_W = $clog2(NMAX + 1);

  logic                    cal_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [RAW_W-1:0] acc_x_q;
  logic signed [RAW_W-1:0] acc_y_q;
  logic signed [ZW-1:0]    acc_z_q;
  acc_ctl_t                ctl_q;
  logic signed [RAW_W-1:0] sum_x_q;
  logic signed [RAW_W-1:0] sum_y_q;
  logic signed [ZW-1:0]    sum_z_q;

  logic [CNT_W-1:0]        cnt_n;
  logic [CNT_W-1:0]        limit;
  logic                    done;
  logic signed [RAW_W-1:0] sx;
  logic signed [RAW_W-1:0] sy;
  logic signed [ZW-1:0]    sz;

  always_comb begin
    cnt_n = cnt_q + CNT_W'(1);
    limit = cal_q ? CNT_W'(GROUP_SAMPLES) : CNT_W'(CAL_SAMPLES);
    done  = (cnt_n >= limit);
    sx    = acc_x_q + RAW_W'(x_i);
    sy    = acc_y_q + RAW_W'(y_i);
    sz    = acc_z_q + ZW'(z_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q   <= 1'b0;
      cnt_q   <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
      ctl_q   <= '{valid: 1'b0, kind: KIND_GRP};
    end else if (en_i) begin
      ctl_q.valid <= valid_i && done;
      ctl_q.kind  <= cal_q ? KIND_GRP : KIND_CAL;
      if (valid_i) begin
        if (done) begin
          cnt_q   <= '0;
          acc_x_q <= '0;
          acc_y_q <= '0;
          acc_z_q <= '0;
          cal_q   <= 1'b1;
        end else begin
          cnt_q   <= cnt_n;
          acc_x_q <= sx;
          acc_y_q <= sy;
          if (cal_q) begin
            acc_z_q <= sz;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_x_q <= sx;
      sum_y_q <= sy;
      sum_z_q <= sz;
    end
  end

  assign ctl_o   = ctl_q;
  assign sum_x_o = sum_x_q;
  assign sum_y_o = sum_y_q;
  assign sum_z_o = sum_z_q;

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < limit) else $error("sample counter beyond its run length");

  a_cal_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cal_q) |-> (cnt_q == '0) && (acc_x_q == '0) && (acc_y_q == '0))
    else $error("calibration did not clear the accumulators");

  a_cal_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.valid && ctl_q.kind == KIND_CAL) |-> cal_q)
    else $error("calibration sum issued while still uncalibrated");
`endif

endmodule
`default_nettype wire

// ===== src/tgd_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving-average window
// Circular store of the latest group means per axis, with registered sums of
// the window as it stands after each push.
// ----------------------------------------------------------------------------
module tgd_window #(
  parameter int unsigned WINDOW_DEPTH = 3,
  parameter int unsigned SUM_W        = 18
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [15:0]      x_i,
  input  wire logic signed [15:0]      y_i,
  input  wire logic signed [15:0]      z_i,
  output logic signed [SUM_W-1:0]      sum_x_o,
  output logic signed [SUM_W-1:0]      sum_y_o,
  output logic signed [SUM_W-1:0]      sum_z_o
);

  localparam int unsigned POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic signed [15:0]      win_x_q [WINDOW_DEPTH];
  logic signed [15:0]      win_y_q [WINDOW_DEPTH];
  logic signed [15:0]      win_z_q [WINDOW_DEPTH];
  logic [POS_W-1:0]        pos_q;
  logic signed [SUM_W-1:0] sum_x_q;
  logic signed [SUM_W-1:0] sum_y_q;
  logic signed [SUM_W-1:0] sum_z_q;
  logic signed [SUM_W-1:0] sum_x_d;
  logic signed [SUM_W-1:0] sum_y_d;
  logic signed [SUM_W-1:0] sum_z_d;

  always_comb begin
    sum_x_d = '0;
    sum_y_d = '0;
    sum_z_d = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (valid_i && pos_q == POS_W'(i)) begin
        sum_x_d = sum_x_d + SUM_W'(x_i);
        sum_y_d = sum_y_d + SUM_W'(y_i);
        sum_z_d = sum_z_d + SUM_W'(z_i);
      end else begin
        sum_x_d = sum_x_d + SUM_W'(win_x_q[i]);
        sum_y_d = sum_y_d + SUM_W'(win_y_q[i]);
        sum_z_d = sum_z_d + SUM_W'(win_z_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_x_q[i] <= '0;
        win_y_q[i] <= '0;
        win_z_q[i] <= '0;
      end
    end else if (en_i && valid_i) begin
      win_x_q[pos_q] <= x_i;
      win_y_q[pos_q] <= y_i;
      win_z_q[pos_q] <= z_i;
      pos_q <= (pos_q == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
    end
  end

  assign sum_x_o = sum_x_q;
  assign sum_y_o = sum_y_q;
  assign sum_z_o = sum_z_q;

`ifndef SYNTHESIS
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(WINDOW_DEPTH - 1)) else $error("window position out of range");
`endif

endmodule
`default_nettype wire

// ===== src/tgd_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gesture classifier
// Decides the tilt direction of the window mean, applies the repeat and
// debounce rules and holds the result register of the block.
// ----------------------------------------------------------------------------
module tgd_classify import tgd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] fx_i,
  input  wire logic signed [15:0] fy_i,
  input  wire logic signed [15:0] fz_i,
  input  wire logic [31:0]        now_i,
  input  wire logic [14:0]        thr_i,
  input  wire logic [14:0]        rel_i,
  input  wire logic [15:0]        deb_i,
  output logic                    valid_o,
  output gesture_e                gesture_o,
  output logic signed [15:0]      fx_o,
  output logic signed [15:0]      fy_o,
  output logic signed [15:0]      fz_o
);

  gesture_e           last_q;
  logic [31:0]        last_ms_q;
  logic               valid_q;
  gesture_e           gesture_q;
  logic signed [15:0] fx_q;
  logic signed [15:0] fy_q;
  logic signed [15:0] fz_q;

  logic [15:0] ax;
  logic [15:0] ay;
  logic        tilt;
  logic        relax;
  logic        late;
  logic        take;
  logic [31:0] elapsed;
  gesture_e    dir;

  always_comb begin
    ax      = fx_i[15] ? 16'(-fx_i) : 16'(fx_i);
    ay      = fy_i[15] ? 16'(-fy_i) : 16'(fy_i);
    tilt    = (ax > {1'b0, thr_i}) || (ay > {1'b0, thr_i});
    relax   = (ax < {1'b0, rel_i}) && (ay < {1'b0, rel_i});
    if (ay > ax) begin
      dir = (fy_i > 16'sd0) ? GEST_FRONT : GEST_BACK;
    end else begin
      dir = (fx_i > 16'sd0) ? GEST_RIGHT : GEST_LEFT;
    end
    elapsed = now_i - last_ms_q;
    late    = elapsed > {16'h0000, deb_i};
    take    = tilt && (dir != last_q) && late;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= GEST_NONE;
      last_ms_q <= '0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        if (take) begin
          last_q    <= dir;
          last_ms_q <= now_i;
        end else if (!tilt && relax) begin
          last_q <= GEST_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      gesture_q <= take ? dir : GEST_NONE;
      fx_q      <= fx_i;
      fy_q      <= fy_i;
      fz_q      <= fz_i;
    end
  end

  assign valid_o   = valid_q;
  assign gesture_o = gesture_q;
  assign fx_o      = fx_q;
  assign fy_o      = fy_q;
  assign fz_o      = fz_q;

`ifndef SYNTHESIS
  a_report_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && gesture_q != GEST_NONE) |-> (last_q == gesture_q))
    else $error("reported gesture not recorded as the last gesture");
`endif

endmodule
`default_nettype wire

// ===== src/tilt_gesture_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt gesture detector
// Takes one accelerometer sample per clock cycle on the input stream. The first
// CAL_SAMPLES samples set the X and Y bias and give no result; after that every
// GROUP_SAMPLES samples give one result transfer carrying the gesture code and the
// moving-average X, Y and Z values. A group's result passes the input register,
// accumulator, bias correction, group divider, window, mean divider and classifier
// output register. Each piece of state (sample accumulator, bias, window, last
// gesture) is updated in a single stage, so a sample can follow in every cycle; a
// stalled output stops the whole pipeline and the input stream waits with it.
// ----------------------------------------------------------------------------
module tilt_gesture_detector import tgd_pkg::*; #(
  parameter int unsigned GROUP_SAMPLES = GROUP_SAMPLES_DEF,
  parameter int unsigned CAL_SAMPLES   = CAL_SAMPLES_DEF,
  parameter int unsigned WINDOW_DEPTH  = WINDOW_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // sample_x[15:0], sample_y[31:16], sample_z[47:32], now_ms[79:48]
  input  wire logic [79:0]           s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // gesture[2:0], filtered_x[18:3], filtered_y[34:19], filtered_z[50:35], zero fill
  output logic [55:0]                m_axis_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned NMAX  = (CAL_SAMPLES > GROUP_SAMPLES) ? CAL_SAMPLES : GROUP_SAMPLES;
  localparam int unsigned RAW_W = 16 + $clog2(NMAX);
  localparam int unsigned ZW    = 16 + $clog2(GROUP_SAMPLES);
  localparam int unsigned CORR_W = ZW + 1;
  localparam int unsigned SUM_W = 16 + $clog2(WINDOW_DEPTH);
  localparam logic signed [ZW-1:0] G_S = ZW'(GROUP_SAMPLES);

  logic        en;
  logic [14:0] thr_q;
  logic [14:0] rel_q;
  logic [15:0] deb_q;

  // Input register.
  logic               v0_q;
  logic signed [15:0] x0_q;
  logic signed [15:0] y0_q;
  logic signed [15:0] z0_q;
  logic [31:0]        now0_q;

  acc_ctl_t                acc_ctl;
  logic signed [RAW_W-1:0] acc_sx;
  logic signed [RAW_W-1:0] acc_sy;
  logic signed [ZW-1:0]    acc_sz;
  logic [31:0]             now1_q;

  acc_ctl_t             cal_ctl_q [2];
  logic signed [ZW-1:0] cal_rx_q  [2];
  logic signed [ZW-1:0] cal_ry_q  [2];
  logic signed [ZW-1:0] cal_rz_q  [2];
  logic [31:0]          cal_now_q [2];
  logic signed [15:0]   bias_x;
  logic signed [15:0]   bias_y;
  logic signed [ZW-1:0] gbias_x_q;
  logic signed [ZW-1:0] gbias_y_q;

  logic                     v3_q;
  logic signed [CORR_W-1:0] cx3_q;
  logic signed [CORR_W-1:0] cy3_q;
  logic signed [CORR_W-1:0] cz3_q;
  logic [31:0]              now3_q;

  logic               grp_v_q   [2];
  logic [31:0]        grp_now_q [2];
  logic signed [15:0] gx;
  logic signed [15:0] gy;
  logic signed [15:0] gz;

  logic                    win_v_q;
  logic [31:0]             win_now_q;
  logic signed [SUM_W-1:0] wsum_x;
  logic signed [SUM_W-1:0] wsum_y;
  logic signed [SUM_W-1:0] wsum_z;

  logic               mean_v_q   [2];
  logic [31:0]        mean_now_q [2];
  logic signed [15:0] fx;
  logic signed [15:0] fy;
  logic signed [15:0] fz;

  gesture_e           out_gesture;
  logic signed [15:0] out_fx;
  logic signed [15:0] out_fy;
  logic signed [15:0] out_fz;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= TILT_THRESHOLD_RST;
      rel_q <= RELEASE_LEVEL_RST;
      deb_q <= DEBOUNCE_MS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_TILT_THRESHOLD: thr_q <= pwdata[14:0];
        REG_RELEASE_LEVEL:  rel_q <= pwdata[14:0];
        REG_DEBOUNCE_MS:    deb_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TILT_THRESHOLD: prdata = 32'(thr_q);
      REG_RELEASE_LEVEL:  prdata = 32'(rel_q);
      REG_DEBOUNCE_MS:    prdata = 32'(deb_q);
      default:            prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Control pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        cal_ctl_q[i] <= '{valid: 1'b0, kind: KIND_GRP};
        grp_v_q[i]   <= 1'b0;
        mean_v_q[i]  <= 1'b0;
      end
      v3_q    <= 1'b0;
      win_v_q <= 1'b0;
    end else if (en) begin
      v0_q         <= s_axis_tvalid;
      cal_ctl_q[0] <= acc_ctl;
      cal_ctl_q[1] <= cal_ctl_q[0];
      v3_q         <= cal_ctl_q[1].valid && (cal_ctl_q[1].kind == KIND_GRP);
      grp_v_q[0]   <= v3_q;
      grp_v_q[1]   <= grp_v_q[0];
      win_v_q      <= grp_v_q[1];
      mean_v_q[0]  <= win_v_q;
      mean_v_q[1]  <= mean_v_q[0];
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk_i) begin
    if (en && s_axis_tvalid) begin
      x0_q   <= s_axis_tdata[15:0];
      y0_q   <= s_axis_tdata[31:16];
      z0_q   <= s_axis_tdata[47:32];
      now0_q <= s_axis_tdata[79:48];
    end
    if (en) begin
      now1_q       <= now0_q;
      cal_rx_q[0]  <= acc_sx[ZW-1:0];
      cal_ry_q[0]  <= acc_sy[ZW-1:0];
      cal_rz_q[0]  <= acc_sz;
      cal_now_q[0] <= now1_q;
      cal_rx_q[1]  <= cal_rx_q[0];
      cal_ry_q[1]  <= cal_ry_q[0];
      cal_rz_q[1]  <= cal_rz_q[0];
      cal_now_q[1] <= cal_now_q[0];
      cx3_q        <= CORR_W'(cal_rx_q[1]) - CORR_W'(gbias_x_q);
      cy3_q        <= CORR_W'(cal_ry_q[1]) - CORR_W'(gbias_y_q);
      cz3_q        <= CORR_W'(cal_rz_q[1]);
      now3_q       <= cal_now_q[1];
      grp_now_q[0] <= now3_q;
      grp_now_q[1] <= grp_now_q[0];
      win_now_q    <= grp_now_q[1];
      mean_now_q[0] <= win_now_q;
      mean_now_q[1] <= mean_now_q[0];
    end
    if (en && cal_ctl_q[1].valid && cal_ctl_q[1].kind == KIND_CAL) begin
      gbias_x_q <= ZW'(bias_x) * G_S;
      gbias_y_q <= ZW'(bias_y) * G_S;
    end
  end

  tgd_accum #(
    .CAL_SAMPLES  (CAL_SAMPLES),
    .GROUP_SAMPLES(GROUP_SAMPLES),
    .RAW_W        (RAW_W),
    .ZW           (ZW)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v0_q),
    .x_i    (x0_q),
    .y_i    (y0_q),
    .z_i    (z0_q),
    .ctl_o  (acc_ctl),
    .sum_x_o(acc_sx),
    .sum_y_o(acc_sy),
    .sum_z_o(acc_sz)
  );

  tgd_cdiv #(.IN_W(RAW_W), .DIVISOR(CAL_SAMPLES)) u_bias_x (
    .clk_i(clk_i), .en_i(en), .val_i(acc_sx), .q_o(bias_x)
  );

  tgd_cdiv #(.IN_W(RAW_W), .DIVISOR(CAL_SAMPLES)) u_bias_y (
    .clk_i(clk_i), .en_i(en), .val_i(acc_sy), .q_o(bias_y)
  );

  tgd_cdiv #(.IN_W(CORR_W), .DIVISOR(GROUP_SAMPLES)) u_grp_x (
    .clk_i(clk_i), .en_i(en), .val_i(cx3_q), .q_o(gx)
  );

  tgd_cdiv #(.IN_W(CORR_W), .DIVISOR(GROUP_SAMPLES)) u_grp_y (
    .clk_i(clk_i), .en_i(en), .val_i(cy3_q), .q_o(gy)
  );

  tgd_cdiv #(.IN_W(CORR_W), .DIVISOR(GROUP_SAMPLES)) u_grp_z (
    .clk_i(clk_i), .en_i(en), .val_i(cz3_q), .q_o(gz)
  );

  tgd_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(grp_v_q[1]),
    .x_i    (gx),
    .y_i    (gy),
    .z_i    (gz),
    .sum_x_o(wsum_x),
    .sum_y_o(wsum_y),
    .sum_z_o(wsum_z)
  );

  tgd_cdiv #(.IN_W(SUM_W), .DIVISOR(WINDOW_DEPTH)) u_mean_x (
    .clk_i(clk_i), .en_i(en), .val_i(wsum_x), .q_o(fx)
  );

  tgd_cdiv #(.IN_W(SUM_W), .DIVISOR(WINDOW_DEPTH)) u_mean_y (
    .clk_i(clk_i), .en_i(en), .val_i(wsum_y), .q_o(fy)
  );

  tgd_cdiv #(.IN_W(SUM_W), .DIVISOR(WINDOW_DEPTH)) u_mean_z (
    .clk_i(clk_i), .en_i(en), .val_i(wsum_z), .q_o(fz)
  );

  tgd_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (mean_v_q[1]),
    .fx_i     (fx),
    .fy_i     (fy),
    .fz_i     (fz),
    .now_i    (mean_now_q[1]),
    .thr_i    (thr_q),
    .rel_i    (rel_q),
    .deb_i    (deb_q),
    .valid_o  (m_axis_tvalid),
    .gesture_o(out_gesture),
    .fx_o     (out_fx),
    .fy_o     (out_fy),
    .fz_o     (out_fz)
  );

  assign m_axis_tdata = {5'b00000, out_fz, out_fy, out_fx, out_gesture};

endmodule
`default_nettype wire
